// ===== rtl/core/mma_asymptote_and_approx_update_top_macros.svh =====
// assertion macros for the asymptote update block
`ifndef MMA_ASYMPTOTE_AND_APPROX_UPDATE_TOP_MACROS_SVH
`define MMA_ASYMPTOTE_AND_APPROX_UPDATE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// property that must hold at every edge out of reset
`define MMA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition at one edge implies another at the next edge
`define MMA_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define MMA_ASSERT(label, clk, rst, prop, msg)
`define MMA_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// ===== rtl/core/mmaupd_pkg.sv =====
// constants and register codes for the asymptote update block
`default_nettype none
package mmaupd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW        = 47;
  localparam int SPLIT     = 24;

  localparam logic [FRAC_BITS:0] HALF_FX = (FRAC_BITS + 1)'(1 << (FRAC_BITS - 1));

  // fixed point constants, rounded to nearest
  localparam logic [17:0] K_INCR      = 18'(((200 << FRAC_BITS) + 85) / 170);
  localparam logic [17:0] K_DECR      = 18'(((17 << FRAC_BITS) + 10) / 20);
  localparam logic [13:0] K_TENTH     = 14'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic [19:0] K_TEN       = 20'(10 << FRAC_BITS);
  localparam logic [9:0]  K_HUNDREDTH = 10'(((1 << FRAC_BITS) + 50) / 100);
  localparam logic [16:0] K_1001      = 17'(((1001 << FRAC_BITS) + 500) / 1000);
  localparam logic [6:0]  K_0001      = 7'(((1 << FRAC_BITS) + 500) / 1000);

  localparam logic [CW-1:0] MAX47 = {CW{1'b1}};
  localparam logic [16:0]   MAX17 = {17{1'b1}};

  localparam logic [16:0] X_LOWER_RST  = 17'd0;
  localparam logic [16:0] X_UPPER_RST  = 17'd65536;
  localparam logic [15:0] REG_TERM_RST = 16'd1;

  typedef enum logic [1:0] {
    REG_X_LOWER  = 2'd0,
    REG_X_UPPER  = 2'd1,
    REG_REG_TERM = 2'd2
  } cfg_reg_t;

endpackage
`default_nettype wire

// ===== rtl/core/mma_asymptote_and_approx_update_top.sv =====
// moving asymptote update and convex approximation coefficients per design element
`default_nettype none
`include "mma_asymptote_and_approx_update_top_macros.svh"
// One design element enters per clock while the output is not stalled; its result leaves
// from the stage 8 output register. The block is an eight stage pipeline with a valid bit
// per stage, so it sustains one request per cycle and a stall at the output only backs up
// as far as the first empty stage. The stages are: asymptote step products, widen or
// narrow, clamp to 0.01..10 ranges, move limit and b-term products, squares, move limit
// clamps and square rounding, the coefficient products (each product of a 47 bit square
// split into two partial products), and the final add and saturate into the output
// register. Range derived values are registered from the configuration registers, so a
// request may follow a write in the next cycle. The configuration port is always ready.
module mma_asymptote_and_approx_update_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               first_iterations,
  input  logic [16:0]        design_now,
  input  logic [16:0]        design_prev,
  input  logic [16:0]        design_prev2,
  input  logic signed [31:0] lower_prev,
  input  logic signed [31:0] upper_prev,
  input  logic signed [31:0] gradient,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] lower_new,
  output logic signed [31:0] upper_new,
  output logic [16:0]        move_low,
  output logic [16:0]        move_high,
  output logic [46:0]        obj_p,
  output logic [46:0]        obj_q,
  output logic [46:0]        con_p,
  output logic [46:0]        con_q,
  output logic [46:0]        con_b,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data
);

  localparam int NSTG = 8;
  localparam logic signed [35:0] S32_MAX = 36'sd2147483647;
  localparam logic signed [35:0] S32_MIN = -36'sd2147483648;

  typedef struct packed {
    logic               first;
    logic               keep;
    logic [16:0]        x;
    logic signed [31:0] lo;
    logic signed [31:0] up;
    logic signed [51:0] pl;
    logic signed [51:0] pu;
    logic               gneg;
    logic [48:0]        gbig;
    logic [38:0]        gsmall;
  } s1_t;

  typedef struct packed {
    logic               first;
    logic [16:0]        x;
    logic signed [35:0] lo_a;
    logic signed [35:0] up_a;
    logic signed [35:0] b_lo10;
    logic signed [35:0] b_lo100;
    logic signed [35:0] b_up100;
    logic signed [35:0] b_up10;
    logic [31:0]        op;
    logic [31:0]        oq;
  } s2_t;

  typedef struct packed {
    logic [16:0]        x;
    logic signed [31:0] lo;
    logic signed [31:0] up;
    logic [31:0]        op;
    logic [31:0]        oq;
  } s3_t;

  typedef struct packed {
    logic [16:0]        x;
    logic signed [31:0] lo;
    logic signed [31:0] up;
    logic [31:0]        op;
    logic [31:0]        oq;
    logic signed [47:0] tl;
    logic signed [47:0] tu;
    logic [31:0]        mu;
    logic [31:0]        ml;
    logic signed [51:0] cbu;
    logic signed [51:0] cbl;
  } s4_t;

  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] up;
    logic [31:0]        op;
    logic [31:0]        oq;
    logic signed [35:0] alpha_a;
    logic signed [35:0] beta_a;
    logic signed [35:0] a_floor;
    logic signed [35:0] b_ceil;
    logic [63:0]        m2u;
    logic [63:0]        m2l;
    logic signed [36:0] sb;
  } s5_t;

  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] up;
    logic [16:0]        alpha;
    logic [16:0]        beta;
    logic [46:0]        squ;
    logic [46:0]        sql;
    logic [31:0]        op;
    logic [31:0]        oq;
    logic [46:0]        cb;
  } s6_t;

  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] up;
    logic [16:0]        alpha;
    logic [16:0]        beta;
    logic [46:0]        cb;
    logic [54:0]        ph_op;
    logic [55:0]        pl_op;
    logic [54:0]        ph_oq;
    logic [55:0]        pl_oq;
    logic [40:0]        ph_cp;
    logic [41:0]        pl_cp;
    logic [39:0]        ph_cq;
    logic [40:0]        pl_cq;
  } s7_t;

  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] up;
    logic [16:0]        alpha;
    logic [16:0]        beta;
    logic [46:0]        op;
    logic [46:0]        oq;
    logic [46:0]        cp;
    logic [46:0]        cq;
    logic [46:0]        cb;
  } s8_t;

  // rounding shifts, half up
  function automatic logic signed [23:0] rnd40(input logic signed [39:0] p);
    logic signed [39:0] t;
    t = p + $signed(40'(mmaupd_pkg::HALF_FX));
    return 24'(t >>> mmaupd_pkg::FRAC_BITS);
  endfunction

  function automatic logic signed [35:0] rnd48(input logic signed [47:0] p);
    logic signed [47:0] t;
    t = p + $signed(48'(mmaupd_pkg::HALF_FX));
    return 36'(t >>> mmaupd_pkg::FRAC_BITS);
  endfunction

  function automatic logic signed [36:0] rnd52(input logic signed [51:0] p);
    logic signed [51:0] t;
    t = p + $signed(52'(mmaupd_pkg::HALF_FX));
    return 37'(t >>> mmaupd_pkg::FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > S32_MAX) begin
      return 32'(S32_MAX);
    end else if (v < S32_MIN) begin
      return 32'(S32_MIN);
    end
    return 32'(v);
  endfunction

  function automatic logic [16:0] sat17(input logic signed [35:0] v);
    if (v < 36'sd0) begin
      return 17'd0;
    end else if (v > $signed({19'd0, mmaupd_pkg::MAX17})) begin
      return mmaupd_pkg::MAX17;
    end
    return v[16:0];
  endfunction

  function automatic logic [46:0] sq_round(input logic [63:0] m);
    logic [64:0] t;
    t = {1'b0, m} + 65'(mmaupd_pkg::HALF_FX);
    if (|t[64:mmaupd_pkg::FRAC_BITS+mmaupd_pkg::CW]) begin
      return mmaupd_pkg::MAX47;
    end
    return t[mmaupd_pkg::FRAC_BITS+mmaupd_pkg::CW-1:mmaupd_pkg::FRAC_BITS];
  endfunction

  // join the two partial products, round and saturate
  function automatic logic [46:0] combine(input logic [54:0] ph, input logic [55:0] pl);
    logic [79:0] t;
    t = (80'(ph) << mmaupd_pkg::SPLIT) + 80'(pl) + 80'(mmaupd_pkg::HALF_FX);
    if (|t[79:mmaupd_pkg::FRAC_BITS+mmaupd_pkg::CW]) begin
      return mmaupd_pkg::MAX47;
    end
    return t[mmaupd_pkg::FRAC_BITS+mmaupd_pkg::CW-1:mmaupd_pkg::FRAC_BITS];
  endfunction

  // configuration and derived range values
  logic [16:0]        x_lower;
  logic [16:0]        x_upper;
  logic [15:0]        reg_term;
  logic signed [23:0] cfg_half;
  logic signed [23:0] cfg_ten;
  logic signed [23:0] cfg_hundredth;
  logic [17:0]        cfg_cp;
  logic [16:0]        cfg_cq;

  logic signed [23:0] cfg_half_next;
  logic signed [23:0] cfg_ten_next;
  logic signed [23:0] cfg_hundredth_next;

  logic [NSTG:1] vld;
  logic [NSTG:1] adv;

  s1_t s1, s1_next;
  s2_t s2, s2_next;
  s3_t s3, s3_next;
  s4_t s4, s4_next;
  s5_t s5, s5_next;
  s6_t s6, s6_next;
  s7_t s7, s7_next;
  s8_t s8, s8_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_lower  <= mmaupd_pkg::X_LOWER_RST;
      x_upper  <= mmaupd_pkg::X_UPPER_RST;
      reg_term <= mmaupd_pkg::REG_TERM_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        mmaupd_pkg::REG_X_LOWER: begin
          x_lower <= cfg_data;
        end
        mmaupd_pkg::REG_X_UPPER: begin
          x_upper <= cfg_data;
        end
        mmaupd_pkg::REG_REG_TERM: begin
          reg_term <= cfg_data[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin : cfg_derive
    logic signed [39:0] r40;
    r40 = 40'($signed({1'b0, x_upper}) - $signed({1'b0, x_lower}));
    cfg_half_next      = rnd40(r40 * $signed({1'b0, mmaupd_pkg::HALF_FX}));
    cfg_ten_next       = rnd40(r40 * $signed({1'b0, mmaupd_pkg::K_TEN}));
    cfg_hundredth_next = rnd40(r40 * $signed({1'b0, mmaupd_pkg::K_HUNDREDTH}));
  end

  always_ff @(posedge clk) begin
    cfg_half      <= cfg_half_next;
    cfg_ten       <= cfg_ten_next;
    cfg_hundredth <= cfg_hundredth_next;
    cfg_cp        <= 18'(mmaupd_pkg::K_1001) + 18'(reg_term);
    cfg_cq        <= 17'(mmaupd_pkg::K_0001) + 17'(reg_term);
  end

  // stall chain: a stage moves when it is empty or the next one moves
  always_comb begin
    adv[NSTG] = !vld[NSTG] || out_ready;
    for (int i = NSTG - 1; i >= 1; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[1];
  assign out_valid = vld[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= in_valid;
      end
      for (int i = 2; i <= NSTG; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 1: direction of the last two steps and the step products
  always_comb begin : st1
    logic               same;
    logic               flip;
    logic [17:0]        k;
    logic signed [32:0] dl;
    logic signed [32:0] du;
    logic [31:0]        ga;
    same = (design_now > design_prev && design_prev > design_prev2) ||
           (design_now < design_prev && design_prev < design_prev2);
    flip = (design_now > design_prev && design_prev < design_prev2) ||
           (design_now < design_prev && design_prev > design_prev2);
    k  = same ? mmaupd_pkg::K_INCR : mmaupd_pkg::K_DECR;
    dl = $signed({16'd0, design_prev}) - 33'(lower_prev);
    du = 33'(upper_prev) - $signed({16'd0, design_prev});
    ga = gradient[31] ? unsigned'(32'(-gradient)) : unsigned'(gradient);
    s1_next.first  = first_iterations;
    s1_next.keep   = !(same || flip);
    s1_next.x      = design_now;
    s1_next.lo     = lower_prev;
    s1_next.up     = upper_prev;
    s1_next.pl     = dl * $signed({1'b0, k});
    s1_next.pu     = du * $signed({1'b0, k});
    s1_next.gneg   = gradient[31];
    s1_next.gbig   = ga * mmaupd_pkg::K_1001;
    s1_next.gsmall = ga * mmaupd_pkg::K_0001;
  end

  // stage 2: widened, narrowed or initial asymptotes and the clamp bounds
  always_comb begin : st2
    logic signed [35:0] xs;
    logic [31:0]        rb;
    logic [31:0]        rs;
    xs = $signed({19'd0, s1.x});
    rb = 32'((s1.gbig + 49'(mmaupd_pkg::HALF_FX)) >> mmaupd_pkg::FRAC_BITS);
    rs = 32'((s1.gsmall + 39'(mmaupd_pkg::HALF_FX)) >> mmaupd_pkg::FRAC_BITS);
    if (s1.first) begin
      s2_next.lo_a = xs - 36'(cfg_half);
      s2_next.up_a = xs + 36'(cfg_half);
    end else if (s1.keep) begin
      s2_next.lo_a = 36'(s1.lo);
      s2_next.up_a = 36'(s1.up);
    end else begin
      s2_next.lo_a = xs - 36'(rnd52(s1.pl));
      s2_next.up_a = xs + 36'(rnd52(s1.pu));
    end
    s2_next.first   = s1.first;
    s2_next.x       = s1.x;
    s2_next.b_lo10  = xs - 36'(cfg_ten);
    s2_next.b_lo100 = xs - 36'(cfg_hundredth);
    s2_next.b_up100 = xs + 36'(cfg_hundredth);
    s2_next.b_up10  = xs + 36'(cfg_ten);
    // positive gradient weighs the upper side, negative the lower
    s2_next.op = (s1.gneg ? rs : rb) + 32'(reg_term);
    s2_next.oq = (s1.gneg ? rb : rs) + 32'(reg_term);
  end

  // stage 3: clamp in order outside the first iterations, the second bound wins on an inverted range
  always_comb begin : st3
    logic signed [35:0] lo;
    logic signed [35:0] up;
    lo = s2.lo_a;
    up = s2.up_a;
    if (!s2.first) begin
      if (lo < s2.b_lo10) begin
        lo = s2.b_lo10;
      end
      if (lo > s2.b_lo100) begin
        lo = s2.b_lo100;
      end
      if (up < s2.b_up100) begin
        up = s2.b_up100;
      end
      if (up > s2.b_up10) begin
        up = s2.b_up10;
      end
    end
    s3_next.x  = s2.x;
    s3_next.lo = sat32(lo);
    s3_next.up = sat32(up);
    s3_next.op = s2.op;
    s3_next.oq = s2.oq;
  end

  // stage 4: distances to the asymptotes and their products
  always_comb begin : st4
    logic signed [33:0] dxl;
    logic signed [33:0] dxu;
    logic signed [33:0] ux;
    dxl = $signed({17'd0, s3.x}) - 34'(s3.lo);
    dxu = $signed({17'd0, s3.x}) - 34'(s3.up);
    ux  = -dxu;
    s4_next.x   = s3.x;
    s4_next.lo  = s3.lo;
    s4_next.up  = s3.up;
    s4_next.op  = s3.op;
    s4_next.oq  = s3.oq;
    s4_next.tl  = dxl * $signed({1'b0, mmaupd_pkg::K_TENTH});
    s4_next.tu  = dxu * $signed({1'b0, mmaupd_pkg::K_TENTH});
    s4_next.mu  = dxu[33] ? 32'(ux) : 32'(dxu);
    s4_next.ml  = dxl[33] ? 32'(-dxl) : 32'(dxl);
    s4_next.cbu = ux * $signed({1'b0, cfg_cp});
    s4_next.cbl = dxl * $signed({1'b0, cfg_cq});
  end

  // stage 5: move limit candidates, squares, b term sum
  always_comb begin : st5
    logic signed [35:0] xs;
    xs = $signed({19'd0, s4.x});
    s5_next.lo      = s4.lo;
    s5_next.up      = s4.up;
    s5_next.op      = s4.op;
    s5_next.oq      = s4.oq;
    s5_next.alpha_a = 36'(s4.lo) + rnd48(s4.tl);
    s5_next.beta_a  = 36'(s4.up) + rnd48(s4.tu);
    s5_next.a_floor = xs - 36'(cfg_half);
    s5_next.b_ceil  = xs + 36'(cfg_half);
    s5_next.m2u     = s4.mu * s4.mu;
    s5_next.m2l     = s4.ml * s4.ml;
    s5_next.sb      = rnd52(s4.cbu) + rnd52(s4.cbl);
  end

  // stage 6: move limit clamps, rounded squares, b term floor at zero
  always_comb begin : st6
    logic signed [35:0] a;
    logic signed [35:0] b;
    a = s5.alpha_a;
    if (a < s5.a_floor) begin
      a = s5.a_floor;
    end
    if (a < $signed({19'd0, x_lower})) begin
      a = $signed({19'd0, x_lower});
    end
    b = s5.beta_a;
    if (b > s5.b_ceil) begin
      b = s5.b_ceil;
    end
    if (b > $signed({19'd0, x_upper})) begin
      b = $signed({19'd0, x_upper});
    end
    s6_next.lo    = s5.lo;
    s6_next.up    = s5.up;
    s6_next.alpha = sat17(a);
    s6_next.beta  = sat17(b);
    s6_next.squ   = sq_round(s5.m2u);
    s6_next.sql   = sq_round(s5.m2l);
    s6_next.op    = s5.op;
    s6_next.oq    = s5.oq;
    s6_next.cb    = s5.sb[36] ? 47'd0 : 47'(s5.sb);
  end

  // stage 7: coefficient partial products, square split in high and low parts
  always_comb begin : st7
    s7_next.lo    = s6.lo;
    s7_next.up    = s6.up;
    s7_next.alpha = s6.alpha;
    s7_next.beta  = s6.beta;
    s7_next.cb    = s6.cb;
    s7_next.ph_op = s6.squ[mmaupd_pkg::CW-1:mmaupd_pkg::SPLIT] * s6.op;
    s7_next.pl_op = s6.squ[mmaupd_pkg::SPLIT-1:0] * s6.op;
    s7_next.ph_oq = s6.sql[mmaupd_pkg::CW-1:mmaupd_pkg::SPLIT] * s6.oq;
    s7_next.pl_oq = s6.sql[mmaupd_pkg::SPLIT-1:0] * s6.oq;
    s7_next.ph_cp = s6.squ[mmaupd_pkg::CW-1:mmaupd_pkg::SPLIT] * cfg_cp;
    s7_next.pl_cp = s6.squ[mmaupd_pkg::SPLIT-1:0] * cfg_cp;
    s7_next.ph_cq = s6.sql[mmaupd_pkg::CW-1:mmaupd_pkg::SPLIT] * cfg_cq;
    s7_next.pl_cq = s6.sql[mmaupd_pkg::SPLIT-1:0] * cfg_cq;
  end

  // stage 8: final sums into the output register
  always_comb begin : st8
    s8_next.lo    = s7.lo;
    s8_next.up    = s7.up;
    s8_next.alpha = s7.alpha;
    s8_next.beta  = s7.beta;
    s8_next.op    = combine(s7.ph_op, s7.pl_op);
    s8_next.oq    = combine(s7.ph_oq, s7.pl_oq);
    s8_next.cp    = combine(55'(s7.ph_cp), 56'(s7.pl_cp));
    s8_next.cq    = combine(55'(s7.ph_cq), 56'(s7.pl_cq));
    s8_next.cb    = s7.cb;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1 <= s1_next;
    end
    if (adv[2]) begin
      s2 <= s2_next;
    end
    if (adv[3]) begin
      s3 <= s3_next;
    end
    if (adv[4]) begin
      s4 <= s4_next;
    end
    if (adv[5]) begin
      s5 <= s5_next;
    end
    if (adv[6]) begin
      s6 <= s6_next;
    end
    if (adv[7]) begin
      s7 <= s7_next;
    end
    if (adv[8]) begin
      s8 <= s8_next;
    end
  end

  assign lower_new = s8.lo;
  assign upper_new = s8.up;
  assign move_low  = s8.alpha;
  assign move_high = s8.beta;
  assign obj_p     = s8.op;
  assign obj_q     = s8.oq;
  assign con_p     = s8.cp;
  assign con_q     = s8.cq;
  assign con_b     = s8.cb;

  `MMA_ASSERT(a_ready_on_bubble, clk, rst, !(&vld) |-> in_ready, "empty stage but input stalled")
  `MMA_ASSERT_NEXT(a_accept_enters, clk, rst, in_valid && in_ready, vld[1], "accepted request lost")
  `MMA_ASSERT_NEXT(a_stall_holds, clk, rst, vld[4] && !adv[4], vld[4] && $stable(s4), "stalled stage changed")
  `MMA_ASSERT_NEXT(a_drain, clk, rst, out_valid && out_ready && !vld[NSTG-1], !out_valid, "result repeated")

endmodule
`default_nettype wire
